FILE: design/pds_pkg.sv
// shared types and constants for the phase duration statistics core
`default_nettype none
package pds_pkg;
  localparam int unsigned PhaseCount = 64;
  localparam int unsigned PhaseBits  = 6;
  localparam int unsigned TimeBits   = 48;

  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_STOP   = 3'd1,
    REQ_SAMPLE = 3'd2,
    REQ_TOKENS = 3'd3,
    REQ_STEP   = 3'd4,
    REQ_QUERY  = 3'd5,
    REQ_CLEAR  = 3'd6,
    REQ_NONE   = 3'd7
  } req_e;

  // the last code only marks the reset sweep inside the core, never a beat
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_IDLE     = 3'd3,
    ST_NEGATIVE = 3'd4,
    ST_SWEEP    = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIV, S_OUT, S_CLEAR
  } fsm_e;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [PhaseBits-1:0] phase;
    logic [47:0]         now;
    logic signed [47:0]  sample_ticks;
    logic [31:0]         token_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] measured_ticks;
    logic        is_running;
    logic [31:0] call_count;
    logic [63:0] total_ticks;
    logic [47:0] min_ticks;
    logic [47:0] max_ticks;
    logic [63:0] average_ticks;
    logic [31:0] processed_steps;
    logic [63:0] processed_tokens;
  } rsp_t;

  // one phase entry of the statistics memory
  typedef struct packed {
    logic [31:0] cnt;
    logic [63:0] tot;
    logic [47:0] mn;
    logic [47:0] mx;
  } stat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

FILE: design/pds_if.sv
// valid/ready channel interfaces for requests and responses
`default_nettype none
interface pds_req_if;
  logic         valid;
  logic         ready;
  pds_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pds_rsp_if;
  logic         valid;
  logic         ready;
  pds_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/pds_div.sv
// 64 by 32 bit restoring divider, one quotient bit per cycle
`default_nettype none
module pds_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pds_pkg::div_req_t req_i,
  output logic                  busy_o,
  output logic [63:0]           quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  // load on start, else shift in the next dividend bit and try a subtract
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    trial  = {rem_q[31:0], quot_q[63]};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd64;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign quot_o = quot_q;
endmodule
`default_nettype wire

FILE: design/phase_duration_statistics_core.sv
// top level: request sequencer over the per-phase statistics memories
//
// Requests arrive on req (valid/ready) and each gives exactly one beat on
// rsp. The enable register is written through cfg_we_i/cfg_wdata_i.
// Per-phase state sits in two synchronous memories (start stamps and
// statistics) with a registered read; running flags are flip-flops.
// Each request reads its phase entry when accepted, then modifies and
// writes it back in S_READ while the response is registered; S_OUT then
// gives the response beat. A query on a phase with samples first runs
// the serial divider for the average in S_DIV. Only one request is in
// flight; the next is accepted in the cycle after its response beat is
// taken. A stalled receiver holds the response register and blocks new
// requests. After reset, and after a clear request, a sweep writes every
// entry of the statistics memory to zero; no request is accepted during
// the sweep. A clear response is given after its sweep ends. Enable
// resets to zero.
`default_nettype none
module phase_duration_statistics_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  pds_req_if.sink    req,
  pds_rsp_if.source  rsp
);
  localparam int unsigned PB = pds_pkg::PhaseBits;

  pds_pkg::fsm_e state_q, state_d;
  logic          en_q;
  pds_pkg::req_t cur_q;
  pds_pkg::rsp_t out_q, out_d;
  logic [pds_pkg::PhaseCount-1:0] run_q, run_d;
  logic [31:0] steps_q, steps_d;
  logic [63:0] tok_q, tok_d;
  logic [PB:0] clr_q, clr_d;

  // memories
  logic [47:0]          stamp_mem [pds_pkg::PhaseCount];
  pds_pkg::stat_t       stat_mem  [pds_pkg::PhaseCount];
  logic [47:0]          stamp_rd;
  pds_pkg::stat_t       stat_rd, stat_wd;
  logic                 stat_we, stamp_we;
  logic [PB-1:0]        stat_wa;

  pds_pkg::div_req_t    div_req;
  logic                 div_busy;
  logic [63:0]          div_quot;

  logic                 accept;
  assign accept = req.valid && req.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stamp_rd <= stamp_mem[req.data.phase];
      stat_rd  <= stat_mem[req.data.phase];
    end
    if (stamp_we) begin
      stamp_mem[cur_q.phase] <= cur_q.now;
    end
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
  end

  pds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pds_pkg::S_IDLE:  if (accept) state_d = pds_pkg::S_READ;
      pds_pkg::S_READ: begin
        if (cur_q.req_type == pds_pkg::REQ_CLEAR) state_d = pds_pkg::S_CLEAR;
        else if (cur_q.req_type == pds_pkg::REQ_QUERY && stat_rd.cnt != '0)
          state_d = pds_pkg::S_DIV;
        else state_d = pds_pkg::S_OUT;
      end
      pds_pkg::S_DIV:   if (!div_busy && !div_req.start) state_d = pds_pkg::S_OUT;
      pds_pkg::S_OUT:   if (rsp.ready) state_d = pds_pkg::S_IDLE;
      pds_pkg::S_CLEAR: if (clr_q[PB]) state_d = pds_pkg::S_OUT;
      default:          state_d = pds_pkg::S_IDLE;
    endcase
  end

  // clear sweep, divider start, and read-modify-write of the phase entry and the result
  always_comb begin
    logic [47:0] d;
    logic [64:0] sum;
    logic        fold;
    logic [32:0] tsum;
    req.ready = (state_q == pds_pkg::S_IDLE);
    out_d     = out_q;
    run_d     = run_q;
    steps_d   = steps_q;
    tok_d     = tok_q;
    clr_d     = clr_q;
    stat_we   = 1'b0;
    stamp_we  = 1'b0;
    stat_wa   = cur_q.phase;
    stat_wd   = stat_rd;
    div_req   = '0;
    fold      = 1'b0;
    d         = '0;
    sum       = '0;
    tsum      = '0;
    if (state_q == pds_pkg::S_CLEAR) begin
      stat_we = !clr_q[PB];
      stat_wa = clr_q[PB-1:0];
      stat_wd = '0;
      clr_d   = clr_q + (PB+1)'(1);
    end
    if (state_q == pds_pkg::S_DIV && out_q.average_ticks == '1 && !div_busy)
      out_d.average_ticks = div_quot;
    if (state_q == pds_pkg::S_READ) begin
      out_d = '0;
      if (cur_q.req_type <= pds_pkg::REQ_STEP && !en_q) begin
        out_d.status = pds_pkg::ST_DISABLED;
      end else begin
        case (cur_q.req_type)
          pds_pkg::REQ_START: begin
            if (run_q[cur_q.phase]) out_d.status = pds_pkg::ST_RUNNING;
            else begin
              run_d[cur_q.phase] = 1'b1;
              stamp_we = 1'b1;
            end
          end
          pds_pkg::REQ_STOP: begin
            if (!run_q[cur_q.phase]) out_d.status = pds_pkg::ST_IDLE;
            else begin
              run_d[cur_q.phase] = 1'b0;
              d    = cur_q.now - stamp_rd;
              fold = 1'b1;
            end
          end
          pds_pkg::REQ_SAMPLE: begin
            if (cur_q.sample_ticks[47]) out_d.status = pds_pkg::ST_NEGATIVE;
            else begin
              d    = cur_q.sample_ticks;
              fold = 1'b1;
            end
          end
          pds_pkg::REQ_TOKENS: begin
            sum   = {1'b0, tok_q} + {33'd0, cur_q.token_count};
            tok_d = sum[64] ? '1 : sum[63:0];
          end
          pds_pkg::REQ_STEP: begin
            tsum    = {1'b0, steps_q} + 33'd1;
            steps_d = tsum[32] ? steps_q : tsum[31:0];
          end
          pds_pkg::REQ_QUERY: begin
            out_d.is_running       = run_q[cur_q.phase];
            out_d.call_count       = stat_rd.cnt;
            out_d.total_ticks      = stat_rd.tot;
            out_d.min_ticks        = stat_rd.mn;
            out_d.max_ticks        = stat_rd.mx;
            out_d.processed_steps  = steps_q;
            out_d.processed_tokens = tok_q;
            if (stat_rd.cnt != '0) begin
              out_d.average_ticks = '1;
              div_req.start    = 1'b1;
              div_req.dividend = stat_rd.tot;
              div_req.divisor  = stat_rd.cnt;
            end
          end
          pds_pkg::REQ_CLEAR: begin
            run_d   = '0;
            steps_d = '0;
            tok_d   = '0;
            clr_d   = '0;
          end
          default: ;
        endcase
      end
      if (fold) begin
        out_d.measured_ticks = d;
        stat_we = 1'b1;
        if (stat_rd.cnt == '0) begin
          stat_wd.mn = d;
          stat_wd.mx = d;
        end else begin
          if (d < stat_rd.mn) stat_wd.mn = d;
          if (d > stat_rd.mx) stat_wd.mx = d;
        end
        sum = {1'b0, stat_rd.tot} + {17'd0, d};
        stat_wd.tot = sum[64] ? '1 : sum[63:0];
        if (stat_rd.cnt != '1) stat_wd.cnt = stat_rd.cnt + 32'd1;
      end
    end
  end

  // the divider's busy flag is registered from its start request; div_wait_q always stays low
  logic div_wait_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pds_pkg::S_CLEAR;
      en_q       <= 1'b0;
      run_q      <= '0;
      steps_q    <= '0;
      tok_q      <= '0;
      clr_q      <= '0;
      div_wait_q <= 1'b0;
    end else begin
      state_q    <= (state_q == pds_pkg::S_CLEAR && clr_q[PB] && !div_wait_q &&
                     out_q.status == pds_pkg::ST_SWEEP) ? pds_pkg::S_IDLE : state_d;
      div_wait_q <= 1'b0;
      if (cfg_we_i) en_q <= cfg_wdata_i;
      run_q   <= run_d;
      steps_q <= steps_d;
      tok_q   <= tok_d;
      clr_q   <= clr_d;
    end
  end

  // response register; the sweep status marks the reset sweep, which gives no beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= {pds_pkg::ST_SWEEP, {($bits(pds_pkg::rsp_t) - 3){1'b0}}};
    end else if (accept) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cur_q <= req.data;
  end

  assign rsp.valid = (state_q == pds_pkg::S_OUT);
  assign rsp.data  = out_q;
endmodule
`default_nettype wire
